FILE: design/lfs_pkg.sv
// Shared codes, constants and command type of the lamp frame sequencer.
package lfs_pkg;

    // Operation codes on the request channel
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_WR_BYTE  = 3'd3;
    localparam logic [2:0] OP_WR_LEN   = 3'd4;

    // Play order codes
    localparam logic [1:0] DIR_FWD     = 2'd0;
    localparam logic [1:0] DIR_BWD     = 2'd1;
    localparam logic [1:0] DIR_PING    = 2'd2;

    localparam logic [15:0] HOLD_RESET = 16'd100;
    localparam logic [15:0] TICK_MAX   = 16'hFFFF;
    localparam logic [7:0]  BYTE_ALL   = 8'hFF;
    localparam int          BANK_BITS  = 8;
    localparam int          EMIT_LIMIT = 8;
    localparam int          QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_WR_BYTE,
        CMD_WR_LEN
    } cmd_kind_t;

    // Classified request as it travels from the front end to the player
    typedef struct packed {
        cmd_kind_t   kind;
        logic [2:0]  anim;
        logic [1:0]  dir;
        logic [7:0]  runs;
        logic [15:0] dur;
        logic [4:0]  frame;
        logic [2:0]  bank;
        logic [7:0]  data;
        logic [5:0]  total;
    } lfs_cmd_t;

endpackage

FILE: design/lfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/lfs_front.sv
// Front end: accepts requests, drops ignored ones and classifies the rest.
module lfs_front
    import lfs_pkg::*;
#(
    parameter int ANIMATIONS = 8,
    parameter int MAX_FRAMES = 32,
    parameter int BANKS      = 8
) (
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [2:0]  s_animation_number,
    input  logic [1:0]  s_direction,
    input  logic [7:0]  s_run_count,
    input  logic [15:0] s_frame_duration,
    input  logic [4:0]  s_frame_index,
    input  logic [2:0]  s_bank_index,
    input  logic [7:0]  s_data_byte,
    input  logic [5:0]  s_frame_total,
    input  logic        q_full,
    output logic        q_push,
    output lfs_cmd_t    q_cmd
);

    logic keep;
    logic anim_ok;

    assign anim_ok = int'(s_animation_number) < ANIMATIONS;

    // Decode operation, check ranges, normalize direction
    always_comb begin
        keep        = 1'b0;
        q_cmd.kind  = CMD_TICK;
        q_cmd.anim  = s_animation_number;
        q_cmd.dir   = (s_direction == DIR_BWD || s_direction == DIR_PING) ? s_direction : DIR_FWD;
        q_cmd.runs  = s_run_count;
        q_cmd.dur   = s_frame_duration;
        q_cmd.frame = s_frame_index;
        q_cmd.bank  = s_bank_index;
        q_cmd.data  = s_data_byte;
        q_cmd.total = s_frame_total;
        unique case (s_operation)
            OP_TICK: begin
                keep       = 1'b1;
                q_cmd.kind = CMD_TICK;
            end
            OP_START: begin
                keep       = anim_ok;
                q_cmd.kind = CMD_START;
            end
            OP_STOP: begin
                keep       = 1'b1;
                q_cmd.kind = CMD_STOP;
            end
            OP_WR_BYTE: begin
                keep       = anim_ok && (int'(s_frame_index) < MAX_FRAMES)
                             && (int'(s_bank_index) < BANKS);
                q_cmd.kind = CMD_WR_BYTE;
            end
            OP_WR_LEN: begin
                keep       = anim_ok;
                q_cmd.kind = CMD_WR_LEN;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && keep;

endmodule

FILE: design/lfs_queue.sv
// Two-entry command queue between the front end and the player.
module lfs_queue
    import lfs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  lfs_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output lfs_cmd_t head_cmd
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    lfs_cmd_t        slot_reg [QUEUE_DEPTH];
    logic [QW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QW:0]     count_reg, count_next;

    assign full       = (count_reg == (QW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: design/lfs_back.sv
// Player: executes commands, steps frames and streams banks from the frame RAM.
module lfs_back
    import lfs_pkg::*;
#(
    parameter int ANIMATIONS = 8,
    parameter int MAX_FRAMES = 32,
    parameter int BANKS      = 8,
    parameter int LAMP_COUNT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  lfs_cmd_t    q_cmd,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_bank,
    output logic [7:0]  m_lamp_bits,
    output logic        m_last_bank,
    output logic        m_still_running
);

    localparam int STORE = ANIMATIONS * MAX_FRAMES * BANKS;
    localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int PW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int LT    = (ANIMATIONS < 8) ? ANIMATIONS : 8;
    localparam int LTW   = (LT > 1) ? $clog2(LT) : 1;
    localparam int EB    = (BANKS < EMIT_LIMIT) ? BANKS : EMIT_LIMIT;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Lamps at or above the lamp count are forced off
    function automatic logic [7:0] lamp_mask(input logic [2:0] bank);
        int first;
        int left;
        logic [7:0] m;
        begin
            first = int'(bank) * BANK_BITS;
            left  = LAMP_COUNT - first;
            if (LAMP_COUNT <= first) begin
                m = 8'd0;
            end else if (left >= BANK_BITS) begin
                m = BYTE_ALL;
            end else begin
                m = 8'((1 << left) - 1);
            end
            return m;
        end
    endfunction

    state_t       state_reg, state_next;
    logic         active_reg, active_next;
    logic [2:0]   anim_reg, anim_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [15:0]  elapsed_reg, elapsed_next;
    logic [15:0]  hold_reg, hold_next;
    logic [1:0]   order_reg, order_next;
    logic [7:0]   runs_reg, runs_next;
    logic         endless_reg, endless_next;
    logic         up_reg, up_next;
    logic [2:0]   bank_reg, bank_next;

    logic         rd_pend_reg, rd_pend_next;
    logic [2:0]   rd_bank_reg, rd_bank_next;
    logic         rd_last_reg, rd_last_next;
    logic         rd_run_reg, rd_run_next;

    logic         m_valid_reg, m_valid_next;
    logic [2:0]   m_bank_reg;
    logic [7:0]   m_bits_reg;
    logic         m_last_reg;
    logic         m_run_reg;

    logic [5:0]   len_tab [LT];
    logic [2:0]   lt_anim;
    logic [5:0]   len;
    logic [CW-1:0] fcount;
    logic         lt_we;

    logic [PW-1:0] step_pos;
    logic         step_up;
    logic         step_done;
    logic [PW:0]  pos_inc;
    logic [PW:0]  fcount_ext;
    logic [15:0]  el_inc;
    logic [7:0]   runs_dec;

    logic         ram_we;
    logic         ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]   ram_rdata;
    logic         out_load;
    logic         can_issue;

    // Frame count lookup: zero reads as one, clamped to MAX_FRAMES
    assign lt_anim = (state_reg == ST_IDLE && q_cmd.kind == CMD_START) ? q_cmd.anim : anim_reg;
    assign len     = len_tab[lt_anim[LTW-1:0]];

    always_comb begin
        if (len == 6'd0) begin
            fcount = CW'(1);
        end else if (int'(len) > MAX_FRAMES) begin
            fcount = CW'(MAX_FRAMES);
        end else begin
            fcount = CW'(len);
        end
    end

    assign pos_inc    = (PW+1)'(pos_reg) + (PW+1)'(1);
    assign fcount_ext = (PW+1)'(fcount);

    // Next frame: wrap or turn around, flag a finished run
    always_comb begin
        step_pos  = pos_reg;
        step_up   = up_reg;
        step_done = 1'b0;
        case (order_reg)
            DIR_BWD: begin
                if (pos_reg == '0) begin
                    step_pos  = PW'(fcount - CW'(1));
                    step_done = 1'b1;
                end else begin
                    step_pos = pos_reg - 1'b1;
                end
            end
            DIR_PING: begin
                if (up_reg) begin
                    if (pos_inc >= fcount_ext) begin
                        step_up = 1'b0;
                        if (fcount > CW'(1) && pos_reg != '0) begin
                            step_pos = pos_reg - 1'b1;
                        end
                    end else begin
                        step_pos = pos_inc[PW-1:0];
                    end
                end else if (pos_reg == '0) begin
                    step_up   = 1'b1;
                    step_done = 1'b1;
                end else begin
                    step_pos = pos_reg - 1'b1;
                end
            end
            default: begin
                if (pos_inc >= fcount_ext) begin
                    step_pos  = '0;
                    step_done = 1'b1;
                end else begin
                    step_pos = pos_inc[PW-1:0];
                end
            end
        endcase
    end

    assign el_inc   = (elapsed_reg != TICK_MAX) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign runs_dec = runs_reg - 8'd1;

    // Frame RAM addressing
    assign ram_waddr = AW'((int'(q_cmd.anim) * MAX_FRAMES + int'(q_cmd.frame)) * BANKS
                           + int'(q_cmd.bank));
    assign ram_raddr = AW'((int'(anim_reg) * MAX_FRAMES + int'(pos_reg)) * BANKS
                           + int'(bank_reg));

    // Read pipeline into the output register
    assign out_load  = rd_pend_reg && (!m_valid_reg || m_ready);
    assign can_issue = !rd_pend_reg || out_load;

    // Command execution and bank sequencing
    always_comb begin
        state_next   = state_reg;
        active_next  = active_reg;
        anim_next    = anim_reg;
        pos_next     = pos_reg;
        elapsed_next = elapsed_reg;
        hold_next    = hold_reg;
        order_next   = order_reg;
        runs_next    = runs_reg;
        endless_next = endless_reg;
        up_next      = up_reg;
        bank_next    = bank_reg;
        rd_bank_next = rd_bank_reg;
        rd_last_next = rd_last_reg;
        rd_run_next  = rd_run_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        lt_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        CMD_TICK: begin
                            if (active_reg) begin
                                if (el_inc < hold_reg) begin
                                    elapsed_next = el_inc;
                                end else begin
                                    elapsed_next = '0;
                                    pos_next     = step_pos;
                                    up_next      = step_up;
                                    if (step_done && !endless_reg) begin
                                        runs_next = runs_dec;
                                        if (runs_dec == 8'd0) begin
                                            active_next = 1'b0;
                                        end
                                    end
                                    bank_next  = '0;
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        CMD_START: begin
                            active_next  = 1'b1;
                            anim_next    = q_cmd.anim;
                            order_next   = q_cmd.dir;
                            endless_next = (q_cmd.runs == 8'd0);
                            runs_next    = q_cmd.runs;
                            hold_next    = q_cmd.dur;
                            up_next      = 1'b1;
                            pos_next     = (q_cmd.dir == DIR_BWD) ? PW'(fcount - CW'(1)) : '0;
                            elapsed_next = '0;
                            bank_next    = '0;
                            state_next   = ST_EMIT;
                        end
                        CMD_STOP: begin
                            active_next = 1'b0;
                        end
                        CMD_WR_BYTE: begin
                            ram_we = 1'b1;
                        end
                        CMD_WR_LEN: begin
                            lt_we = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (can_issue) begin
                    ram_re       = 1'b1;
                    rd_bank_next = bank_reg;
                    rd_last_next = (bank_reg == 3'(EB - 1));
                    rd_run_next  = active_reg;
                    if (bank_reg == 3'(EB - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        bank_next = bank_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (ram_re) begin
            rd_pend_next = 1'b1;
        end else if (out_load) begin
            rd_pend_next = 1'b0;
        end else begin
            rd_pend_next = rd_pend_reg;
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            anim_reg    <= '0;
            pos_reg     <= '0;
            elapsed_reg <= '0;
            hold_reg    <= HOLD_RESET;
            order_reg   <= DIR_FWD;
            runs_reg    <= '0;
            endless_reg <= 1'b0;
            up_reg      <= 1'b1;
            bank_reg    <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            anim_reg    <= anim_next;
            pos_reg     <= pos_next;
            elapsed_reg <= elapsed_next;
            hold_reg    <= hold_next;
            order_reg   <= order_next;
            runs_reg    <= runs_next;
            endless_reg <= endless_next;
            up_reg      <= up_next;
            bank_reg    <= bank_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
        rd_bank_reg <= rd_bank_next;
        rd_last_reg <= rd_last_next;
        rd_run_reg  <= rd_run_next;
        if (out_load) begin
            m_bank_reg <= rd_bank_reg;
            m_bits_reg <= ram_rdata & lamp_mask(rd_bank_reg);
            m_last_reg <= rd_last_reg;
            m_run_reg  <= rd_run_reg;
        end
    end

    // Frame count table, no reset
    always_ff @(posedge aclk) begin
        if (lt_we) begin
            len_tab[q_cmd.anim[LTW-1:0]] <= q_cmd.total;
        end
    end

    lfs_ram #(
        .WIDTH (BANK_BITS),
        .DEPTH (STORE)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_cmd.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid         = m_valid_reg;
    assign m_out_bank      = m_bank_reg;
    assign m_lamp_bits     = m_bits_reg;
    assign m_last_bank     = m_last_reg;
    assign m_still_running = m_run_reg;

endmodule

FILE: design/lamp_frame_sequencer.sv
// Lamp frame sequencer top level: front end, command queue and player.
//
// Plays stored lamp animations. Write requests load frame bytes and frame
// counts; a start request emits the first frame, tick requests advance it.
// Requests enter a two-entry queue, so s_ready drops only while the queue is
// full. The player takes one request per cycle while it is not streaming
// banks; writes, stops and ticks that do not advance the frame leave the
// player free for the next request. A start or an advancing tick then
// streams min(BANKS, 8) bank results, one per cycle from the single read
// port of the frame RAM while m_ready stays high, and no new request is
// taken until the last bank is read. Results leave through an output
// register; a stall on m_ready holds the bank stream. There is no clearing
// pass after reset: unwritten frame bytes and frame counts read undefined.
module lamp_frame_sequencer
    import lfs_pkg::*;
#(
    parameter int ANIMATIONS = 8,
    parameter int MAX_FRAMES = 32,
    parameter int BANKS      = 8,
    parameter int LAMP_COUNT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [2:0]  s_animation_number,
    input  logic [1:0]  s_direction,
    input  logic [7:0]  s_run_count,
    input  logic [15:0] s_frame_duration,
    input  logic [4:0]  s_frame_index,
    input  logic [2:0]  s_bank_index,
    input  logic [7:0]  s_data_byte,
    input  logic [5:0]  s_frame_total,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_bank,
    output logic [7:0]  m_lamp_bits,
    output logic        m_last_bank,
    output logic        m_still_running
);

    logic     q_full;
    logic     q_push;
    lfs_cmd_t q_push_cmd;
    logic     q_pop;
    logic     q_valid;
    lfs_cmd_t q_head;

    lfs_front #(
        .ANIMATIONS (ANIMATIONS),
        .MAX_FRAMES (MAX_FRAMES),
        .BANKS      (BANKS)
    ) u_front (
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_animation_number (s_animation_number),
        .s_direction        (s_direction),
        .s_run_count        (s_run_count),
        .s_frame_duration   (s_frame_duration),
        .s_frame_index      (s_frame_index),
        .s_bank_index       (s_bank_index),
        .s_data_byte        (s_data_byte),
        .s_frame_total      (s_frame_total),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_cmd              (q_push_cmd)
    );

    lfs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    lfs_back #(
        .ANIMATIONS (ANIMATIONS),
        .MAX_FRAMES (MAX_FRAMES),
        .BANKS      (BANKS),
        .LAMP_COUNT (LAMP_COUNT)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_cmd           (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_bank      (m_out_bank),
        .m_lamp_bits     (m_lamp_bits),
        .m_last_bank     (m_last_bank),
        .m_still_running (m_still_running)
    );

endmodule
